[src/mdio_c22_pkg.sv]
// Shared types and constants for the clause 22 MDIO frame master.
// Used by mdio_c22_frame_core and mdio_clause22_frame_master; no dependencies.
`timescale 1ns / 1ps

package mdio_c22_pkg;

  // Default preamble length, in MDC slots
  localparam int PREAMBLE_BITS_DEF = 32;

  // Frame sections after the preamble
  localparam int HEADER_BITS = 14;  // start, opcode, PHY address, register address
  localparam int TA_BITS     = 2;
  localparam int DATA_BITS   = 16;

  // Request kinds carried on the input item
  localparam logic [1:0] KIND_SLOT  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Start bits followed by opcode, MSB first
  localparam logic [3:0] ST_OP_READ  = 4'h6;  // 01 10
  localparam logic [3:0] ST_OP_WRITE = 4'h5;  // 01 01
  localparam logic [1:0] TA_WRITE    = 2'b10;

  // Read answer while the master is disabled
  localparam logic [15:0] READ_DISABLED = 16'hFFFF;

  // One input item, unpacked
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  phy_address;
    logic [4:0]  register_address;
    logic [15:0] write_data;
    logic        mdio_in;
  } req_t;

  // One result item, unpacked
  typedef struct packed {
    logic        mdio_out;
    logic        mdio_drive;
    logic        clock_pulse;
    logic        busy_res;
    logic        request_accepted;
    logic        read_valid;
    logic [15:0] read_data;
  } res_t;

endpackage

[src/mdio_c22_frame_core.sv]
// Frame sequencer of the clause 22 MDIO master: slot counter and shift registers.
// Depends on mdio_c22_pkg. Produces one result per stepped item, combinationally.
`timescale 1ns / 1ps

module mdio_c22_frame_core import mdio_c22_pkg::*; #(
  parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic enable_i,
  input  logic step_i,   // item accepted this cycle: advance state
  input  req_t req_i,
  output res_t res_o
);

  localparam int END_SLOT = PREAMBLE_BITS + HEADER_BITS + TA_BITS + DATA_BITS;
  localparam int CNT_W    = $clog2(END_SLOT + 1);

  localparam logic [CNT_W-1:0] PRE_END_C  = CNT_W'(PREAMBLE_BITS);
  localparam logic [CNT_W-1:0] HDR_END_C  = CNT_W'(PREAMBLE_BITS + HEADER_BITS);
  localparam logic [CNT_W-1:0] DATA_BEG_C = CNT_W'(PREAMBLE_BITS + HEADER_BITS + TA_BITS);
  localparam logic [CNT_W-1:0] END_C      = CNT_W'(END_SLOT);

  logic             active_r, active_nxt;
  logic             is_read_r, is_read_nxt;
  logic [CNT_W-1:0] slot_r, slot_nxt;
  logic [31:0]      send_r, send_nxt;
  logic [15:0]      recv_r, recv_nxt;

  logic             is_req, req_read, start;
  logic             act_e, rd_e;
  logic [CNT_W-1:0] slot_e;
  logic [31:0]      send_e;
  logic [15:0]      recv_e;

  // Request decode and frame start
  always_comb begin
    is_req   = (req_i.kind == KIND_READ) || (req_i.kind == KIND_WRITE);
    req_read = (req_i.kind == KIND_READ);
    start    = is_req && !active_r && enable_i;

    act_e  = active_r | start;
    rd_e   = start ? req_read : is_read_r;
    slot_e = start ? '0 : slot_r;
    recv_e = start ? 16'h0 : recv_r;
    if (start) begin
      send_e = {(req_read ? ST_OP_READ : ST_OP_WRITE), req_i.phy_address,
                req_i.register_address, (req_read ? 2'b00 : TA_WRITE),
                (req_read ? 16'h0 : req_i.write_data)};
    end else begin
      send_e = send_r;
    end
  end

  // Slot decode: line level, shifts and result
  always_comb begin
    res_o = '0;
    res_o.mdio_out = 1'b1;
    res_o.request_accepted = start;

    active_nxt  = act_e;
    is_read_nxt = rd_e;
    slot_nxt    = slot_e;
    send_nxt    = send_e;
    recv_nxt    = recv_e;

    // disabled read is answered at once
    if (is_req && !active_r && !enable_i && req_read) begin
      res_o.request_accepted = 1'b1;
      res_o.read_valid       = 1'b1;
      res_o.read_data        = READ_DISABLED;
    end

    if (act_e) begin
      res_o.clock_pulse = 1'b1;
      res_o.busy_res    = 1'b1;
      slot_nxt          = slot_e + 1'b1;
      if (slot_e < PRE_END_C) begin
        res_o.mdio_drive = 1'b1;
      end else if (slot_e < END_C) begin
        if (rd_e && (slot_e >= HDR_END_C)) begin
          // turnaround and data: line released
          if (slot_e >= DATA_BEG_C) begin
            recv_nxt = {recv_e[14:0], req_i.mdio_in};
          end
        end else begin
          res_o.mdio_out   = send_e[31];
          res_o.mdio_drive = 1'b1;
          send_nxt         = {send_e[30:0], 1'b0};
        end
      end else begin
        // closing idle bit
        res_o.mdio_drive = 1'b1;
        if (rd_e) begin
          res_o.read_valid = 1'b1;
          res_o.read_data  = recv_e;
        end
        active_nxt = 1'b0;
        slot_nxt   = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      is_read_r <= 1'b0;
      slot_r    <= '0;
    end else if (step_i) begin
      active_r  <= active_nxt;
      is_read_r <= is_read_nxt;
      slot_r    <= slot_nxt;
    end
  end

  // Shift registers
  always_ff @(posedge clk) begin
    if (step_i) begin
      send_r <= send_nxt;
      recv_r <= recv_nxt;
    end
  end

  // Checks
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= END_C)
    else $error("slot counter beyond frame end");

  a_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r != '0) |-> active_r)
    else $error("slot counter running while idle");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> ($past(slot_r) == END_C))
    else $error("frame ended before its last slot");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && start) |=> (active_r && (slot_r == CNT_W'(1))))
    else $error("frame start did not advance to the second slot");

endmodule

[src/mdio_clause22_frame_master.sv]
// Top level of the clause 22 MDIO frame master: stream ports, enable register
// and result register. Depends on mdio_c22_pkg and mdio_c22_frame_core.
`timescale 1ns / 1ps
//
//  channel | ports                          | contents
//  --------+--------------------------------+--------------------------------------
//  in      | in_tvalid/in_tready/tdata/tuser | one MDC slot, optional request
//  out     | out_tvalid/out_tready/tdata/tuser | line levels, status, read result
//  cfg     | cfg_we/cfg_wdata               | enable bit
//
//  One item per cycle while out_tready allows, one result per item, held in the
//  result register; the frame sequencer advances once per accepted item.
//  A frame lasts PREAMBLE_BITS + 33 items from its request.
//  Reset (rst_n low, synchronous) clears enable, the sequencer control state and out_tvalid.
//  A stalled result holds; in_tready follows out_tready when a result waits.

module mdio_clause22_frame_master import mdio_c22_pkg::*; #(
  parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // phy_address[4:0], register_address[9:5],
                                  // write_data[25:10], mdio_in[26], zero[31:27]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // mdio_out[0], mdio_drive[1], clock_pulse[2],
                                  // busy_res[3], request_accepted[4],
                                  // read_data[20:5], zero[23:21]
  output logic [0:0]  out_tuser   // read_valid[0]
);

  logic enable_r;
  logic out_valid_r, out_valid_nxt;
  res_t res_r;
  res_t res;
  req_t req;
  logic step;

  // Handshake
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  // Unpack input item
  always_comb begin
    req.kind             = in_tuser;
    req.phy_address      = in_tdata[4:0];
    req.register_address = in_tdata[9:5];
    req.write_data       = in_tdata[25:10];
    req.mdio_in          = in_tdata[26];
  end

  mdio_c22_frame_core #(
    .PREAMBLE_BITS(PREAMBLE_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .enable_i(enable_r),
    .step_i  (step),
    .req_i   (req),
    .res_o   (res)
  );

  // Enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  // Result register
  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  // Pack result item
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.read_data, res_r.request_accepted, res_r.busy_res,
                       res_r.clock_pulse, res_r.mdio_drive, res_r.mdio_out};
  assign out_tuser  = res_r.read_valid;

endmodule
